@@ sv/crce_pkg.sv @@
// Shared types and constants for the configurable CRC engine.
// No dependencies; imported by every module of the block.
package crce_pkg;

  localparam int CRC_WIDTH = 32;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int OUT_W     = 32;
  localparam int BYTE_W    = 8;

  localparam logic [31:0] POLY_RESET = 32'h0000_1021;

  typedef enum logic [2:0] {
    REG_POLYNOMIAL    = 3'd0,
    REG_INIT_VALUE    = 3'd1,
    REG_FINAL_XOR     = 3'd2,
    REG_REFLECT_DATA  = 3'd3,
    REG_INVERT_OUT    = 3'd4
  } crce_reg_t;

  typedef struct packed {
    logic [CFG_DW-1:0] polynomial;
    logic [CFG_DW-1:0] init_value;
    logic [CFG_DW-1:0] final_xor;
    logic              reflect_data;
    logic              invert_out;
  } crce_cfg_t;

endpackage

@@ sv/crce_regs.sv @@
// APB-style configuration register file of the CRC engine.
// Depends on crce_pkg.
module crce_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [crce_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [crce_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [crce_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output crce_pkg::crce_cfg_t       cfg
);
  import crce_pkg::*;

  crce_cfg_t cfg_r;
  crce_cfg_t cfg_nxt;
  logic      wr_en;
  crce_reg_t reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = crce_reg_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_POLYNOMIAL:    cfg_nxt.polynomial    = cfg_pwdata;
        REG_INIT_VALUE:    cfg_nxt.init_value    = cfg_pwdata;
        REG_FINAL_XOR:     cfg_nxt.final_xor     = cfg_pwdata;
        REG_REFLECT_DATA:  cfg_nxt.reflect_data  = cfg_pwdata[0];
        REG_INVERT_OUT:    cfg_nxt.invert_out    = cfg_pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLYNOMIAL:    cfg_prdata = cfg_r.polynomial;
      REG_INIT_VALUE:    cfg_prdata = cfg_r.init_value;
      REG_FINAL_XOR:     cfg_prdata = cfg_r.final_xor;
      REG_REFLECT_DATA:  cfg_prdata = CFG_DW'(cfg_r.reflect_data);
      REG_INVERT_OUT:    cfg_prdata = CFG_DW'(cfg_r.invert_out);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial    <= POLY_RESET;
      cfg_r.init_value    <= '0;
      cfg_r.final_xor     <= '0;
      cfg_r.reflect_data  <= 1'b0;
      cfg_r.invert_out    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/crce_step.sv @@
// One-byte CRC update: table entry by eight shift-xor steps, both bit orders.
// Depends on crce_pkg.
module crce_step (
  input  logic [crce_pkg::CRC_WIDTH-1:0] crc_in,
  input  logic [crce_pkg::BYTE_W-1:0]    data_byte,
  input  logic [crce_pkg::CRC_WIDTH-1:0] poly,
  input  logic                           reflect,
  output logic [crce_pkg::CRC_WIDTH-1:0] crc_out
);
  import crce_pkg::*;

  logic [BYTE_W-1:0]    idx;
  logic [BYTE_W-1:0]    idx_m;
  logic [CRC_WIDTH-1:0] t;
  logic [CRC_WIDTH-1:0] t_m;
  logic [CRC_WIDTH-1:0] entry;

  always_comb begin
    idx = reflect ? (crc_in[BYTE_W-1:0] ^ data_byte)
                  : (crc_in[CRC_WIDTH-1 -: BYTE_W] ^ data_byte);
    for (int i = 0; i < BYTE_W; i++) begin
      idx_m[i] = idx[BYTE_W-1-i];
    end
    t = CRC_WIDTH'(reflect ? idx_m : idx) << (CRC_WIDTH - BYTE_W);
    for (int s = 0; s < BYTE_W; s++) begin
      t = t[CRC_WIDTH-1] ? ((t << 1) ^ poly) : (t << 1);
    end
    for (int i = 0; i < CRC_WIDTH; i++) begin
      t_m[i] = t[CRC_WIDTH-1-i];
    end
    entry   = reflect ? t_m : t;
    crc_out = reflect ? ((crc_in >> BYTE_W) ^ entry) : ((crc_in << BYTE_W) ^ entry);
  end

endmodule

@@ sv/configurable_crc_engine.sv @@
// Byte-wise CRC engine: one byte accepted per cycle unless the input stalls; the result is
// registered in the output register after the last byte. Input stalls only while a
// finished result waits in the output register and a new last byte is pending.
// Synchronous active-low reset clears the pipeline, the crc register and the registers.
// Depends on crce_pkg, crce_regs, crce_step.
module configurable_crc_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] first_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [crce_pkg::OUT_W-1:0]     out_tdata,  // [31:0] crc_value
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [crce_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [crce_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [crce_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import crce_pkg::*;

  crce_cfg_t            cfg;
  logic                 in_valid_r;
  logic [BYTE_W-1:0]    in_data_r;
  logic                 in_first_r;
  logic                 in_last_r;
  logic [CRC_WIDTH-1:0] crc_r;
  logic [CRC_WIDTH-1:0] crc_nxt;
  logic [CRC_WIDTH-1:0] crc_start;
  logic [CRC_WIDTH-1:0] crc_fin;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 in_accept;
  logic                 adv;

  crce_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign adv       = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_accept = in_tvalid && in_tready;
  assign crc_start = in_first_r ? cfg.init_value[CRC_WIDTH-1:0] : crc_r;

  crce_step u_step (
    .crc_in    (crc_start),
    .data_byte (in_data_r),
    .poly      (cfg.polynomial[CRC_WIDTH-1:0]),
    .reflect   (cfg.reflect_data),
    .crc_out   (crc_nxt)
  );

  assign crc_fin = (cfg.invert_out ? ~crc_nxt : crc_nxt) ^ cfg.final_xor[CRC_WIDTH-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        crc_r <= crc_nxt;
      end
      if (adv && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
    if (adv && in_last_r) begin
      out_data_r <= OUT_W'(crc_fin);
    end
  end

endmodule

@@ sv/crce_checker.sv @@
// Port-level checks for the CRC engine, bound to the top level.
// Depends on crce_pkg and configurable_crc_engine.
module crce_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [crce_pkg::OUT_W-1:0] out_tdata
);
  import crce_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready_only_blocked_by_out: assert property (@(posedge clk)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> CRC_WIDTH) == '0)
    else $error("result bits above crc width set");

endmodule

bind configurable_crc_engine crce_checker u_crce_checker (.*);

@@ tb/configurable_crc_engine_tb.sv @@
// Self-checking testbench for configurable_crc_engine: byte stream in, CRC result out.
// Predicts each checksum with its own byte-wise CRC model and compares every result in order.
// Depends on crce_pkg and the configurable_crc_engine RTL.
module configurable_crc_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crce_pkg::*;

  localparam logic [63:0] MASK64       = (64'd1 << CRC_WIDTH) - 64'd1;
  localparam logic [31:0] CRC_MASK     = MASK64[31:0];
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 88;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] data_byte
  logic                in_tuser;   // [0] first_byte
  logic                in_tlast;   // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;  // [31:0] crc_value
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic [31:0] poly_cfg;
  logic [31:0] init_cfg;
  logic [31:0] fxor_cfg;
  logic        reflect_cfg;
  logic        invert_cfg;
  logic [31:0] crc_reg;

  logic [31:0] pending_crcs[$];
  int          crc_errors = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          holds_requested = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  configurable_crc_engine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] mirror_bits(logic [31:0] v, int nbits);
    logic [31:0] r = '0;
    for (int i = 0; i < nbits; i++) begin
      if (v[i]) r[nbits-1-i] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_table_term(logic [7:0] idx);
    logic [31:0] m;
    logic [63:0] t;
    logic        top;
    m = reflect_cfg ? mirror_bits({24'd0, idx}, 8) : {24'd0, idx};
    t = ({32'd0, m} << (CRC_WIDTH - 8)) & MASK64;
    for (int i = 0; i < 8; i++) begin
      top = t[CRC_WIDTH-1];
      t = (t << 1) & MASK64;
      if (top) t = t ^ {32'd0, poly_cfg & CRC_MASK};
    end
    if (reflect_cfg) t = {32'd0, mirror_bits(t[31:0], CRC_WIDTH)};
    return t[31:0] & CRC_MASK;
  endfunction

  task automatic crc_absorb_byte(logic [7:0] d, logic first_flag, logic last_flag);
    logic [31:0] c;
    logic [31:0] res;
    logic [7:0]  hi;
    if (first_flag) crc_reg = init_cfg & CRC_MASK;
    c = crc_reg & CRC_MASK;
    if (reflect_cfg) begin
      c = (c >> 8) ^ crc_table_term(c[7:0] ^ d);
    end else begin
      hi = c[CRC_WIDTH-1 -: 8];
      c = ((c << 8) & CRC_MASK) ^ crc_table_term(hi ^ d);
    end
    crc_reg = c & CRC_MASK;
    if (last_flag) begin
      res = invert_cfg ? ~crc_reg : crc_reg;
      pending_crcs.push_back((res ^ fxor_cfg) & CRC_MASK);
    end
  endtask

  always @(negedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served = holds_requested;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_crcs.size() == 0) begin
        crc_errors++;
        if (crc_errors <= 10) $display("crc result %h arrived with none pending", out_tdata);
      end else begin
        want = pending_crcs.pop_front();
        if (out_tdata !== want) begin
          crc_errors++;
          if (crc_errors <= 10) $display("crc mismatch: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  // entered and left at a falling edge; valid stays high for the next item
  task automatic send_byte(logic [7:0] d, logic first_flag, logic last_flag);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tuser  = first_flag;
    in_tlast  = last_flag;
    do @(posedge clk); while (!in_tready);
    crc_absorb_byte(d, first_flag, last_flag);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_crcs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(crce_reg_t idx, logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_POLYNOMIAL:    poly_cfg    = value;
      REG_INIT_VALUE:    init_cfg    = value;
      REG_FINAL_XOR:     fxor_cfg    = value;
      REG_REFLECT_DATA:  reflect_cfg = value[0];
      REG_INVERT_OUT:    invert_cfg  = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] poly, logic [31:0] init, logic [31:0] fxor,
                                logic refl, logic inv);
    wait_idle();
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_INIT_VALUE, init);
    write_reg(REG_FINAL_XOR, fxor);
    write_reg(REG_REFLECT_DATA, {31'd0, refl});
    write_reg(REG_INVERT_OUT, {31'd0, inv});
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_message();
    int   len;
    int   kind;
    logic first_flag;
    logic last_flag;
    len  = ($urandom_range(9) == 0) ? $urandom_range(32, 16) : $urandom_range(6, 1);
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      // kind 0: continue without a first byte; 1: restart midway; 2: no last byte
      first_flag = (i == 0 && kind != 0) || (kind == 1 && i != 0 && i == len / 2);
      last_flag  = (i == len - 1) && (kind != 2);
      send_byte(8'($urandom_range(255)), first_flag, last_flag);
    end
  endtask

  task automatic test_default_settings();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
  endtask

  task automatic test_standard_crc32();
    apply_settings(32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++) send_byte(8'h31 + i[7:0], i == 0, i == 8);
    apply_settings(32'h04C1_1DB7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b1);
  endtask

  task automatic test_setting_extremes();
    apply_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    apply_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int start_count;
    for (int phase = 0; phase < 4; phase++) begin
      apply_settings(pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 59; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) send_random_message();
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    apply_settings(32'h04C1_1DB7, pick_word(), pick_word(), 1'b0, 1'b0);
    holds_requested++;
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
    wait_idle();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), i == 0, i == 5);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    poly_cfg    = POLY_RESET;
    init_cfg    = '0;
    fxor_cfg    = '0;
    reflect_cfg = 1'b0;
    invert_cfg  = 1'b0;
    crc_reg     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_settings();
    test_standard_crc32();
    test_setting_extremes();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (crc_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
